// ===== hw/rtl/sorted_record_table_search_defines.svh =====
// assertion macros for the sorted record table
`ifndef SORTED_RECORD_TABLE_SEARCH_DEFINES_SVH
`define SORTED_RECORD_TABLE_SEARCH_DEFINES_SVH

// implication checked on every edge outside reset
`define SRTS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// implication with the consequent checked in the cycle after the antecedent
`define SRTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== hw/rtl/srts_pkg.sv =====
// ----------------------------------------------------------------------------
// srts_pkg
// types and constants shared by the sorted record table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srts_pkg;

  localparam int unsigned TableDepthDefault = 64;
  localparam int unsigned KeyCharsDefault   = 8;

  localparam logic [1:0] ActInsert = 2'd0;
  localparam logic [1:0] ActLookup = 2'd1;
  localparam logic [1:0] ActDump   = 2'd2;

  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StNotFound  = 3'd1;
  localparam logic [2:0] StDuplicate = 3'd2;
  localparam logic [2:0] StFull      = 3'd3;
  localparam logic [2:0] StEmpty     = 3'd4;

  typedef struct packed {
    logic [63:0] key;
    logic [7:0]  cls;
    logic [19:0] cnt;
    logic [23:0] cost;
  } rec_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [63:0] part_key;
    logic [7:0]  part_class;
    logic [19:0] on_hand;
    logic [23:0] cost_cents;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] out_key;
    logic [7:0]  out_class;
    logic [19:0] out_on_hand;
    logic [23:0] out_cost;
    logic [43:0] out_value;
    logic        last_result;
  } out_word_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic ins;    // insert new record at its key position
    logic shift;  // dump: move records one cell toward the head
    logic rot;    // never set; the dump rotation comes from shift
  } cell_ctl_t;

endpackage

// ===== hw/rtl/srts_cell.sv =====
// ----------------------------------------------------------------------------
// srts_cell
// one table slot: holds a record, compares it to the probe key, takes the
// right record on a dump and the left record when an insert shifts the table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srts_cell (
  input  logic              clk_i,
  input  srts_pkg::cell_ctl_t ctl_i,
  input  logic              occ_i,       // this slot holds a record
  input  logic              left_occ_i,
  input  logic              left_gt_i,   // left cell key above probe
  input  logic [63:0]       probe_i,
  input  srts_pkg::rec_t    new_i,
  input  srts_pkg::rec_t    left_rec_i,
  input  srts_pkg::rec_t    right_rec_i, // dump rotation source
  output srts_pkg::rec_t    rec_o,
  output logic              gt_o,
  output logic              eq_o
);

  srts_pkg::rec_t rec_q, rec_d;
  logic           here_gt;

  assign here_gt = occ_i && (rec_q.key > probe_i);
  assign gt_o    = here_gt;
  assign eq_o    = occ_i && (rec_q.key == probe_i);
  assign rec_o   = rec_q;

  always_comb begin
    rec_d = rec_q;
    if (ctl_i.ins) begin
      if (left_occ_i && left_gt_i) begin
        rec_d = left_rec_i;
      end else if (here_gt || !occ_i) begin
        rec_d = new_i;
      end
    end else if (ctl_i.shift) begin
      rec_d = right_rec_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ins || ctl_i.shift) begin
      rec_q <= rec_d;
    end
  end

endmodule

// ===== hw/rtl/sorted_record_table_search.sv =====
// ----------------------------------------------------------------------------
// sorted_record_table_search
// sorted part-record table as a chain of cells with insert, lookup and dump
// ----------------------------------------------------------------------------
// insert and lookup: one word, registered in the pending result then output
// registers; busy only in SOne: a new command can enter before the word is out
// dump of n records: n words back to back (one word when empty) through these
// registers; busy while the dump state reads records from the head cell
// dump rotates the chain, so after n words the table is back in order
// results cannot be stalled; reset empties the table, record contents undefined
`timescale 1ns / 1ps
`include "sorted_record_table_search_defines.svh"

module sorted_record_table_search #(
  parameter int unsigned TABLE_DEPTH = srts_pkg::TableDepthDefault,
  parameter int unsigned KEY_CHARS   = srts_pkg::KeyCharsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  srts_pkg::in_word_t   in_i,
  output logic                 strobe,
  output srts_pkg::out_word_t  out_o
);

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam logic [63:0] KeyMask = ~64'd0 << (8 * (8 - KEY_CHARS));

  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SOne  = 2'd1;
  localparam logic [1:0] SDump = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CntW-1:0]  used_q, used_d, left_q, left_d;
  logic [1:0]       act_q;
  logic [63:0]      probe;
  srts_pkg::rec_t   new_rec;
  srts_pkg::rec_t   recs [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] gt, eq, occ;
  srts_pkg::cell_ctl_t ctl;
  logic             accept;
  logic             hit, full;
  srts_pkg::rec_t   hit_rec;

  // pending result for multiply stage
  logic             p_vld_q;
  logic [2:0]       p_st_q, p_st_d;
  srts_pkg::rec_t   p_rec_q, p_rec_d;
  logic             p_last_q, p_last_d;
  logic             p_zero_q, p_zero_d;
  srts_pkg::in_word_t in_q;

  assign accept = start && !busy;
  assign busy   = (state_q != SIdle);
  assign probe  = in_q.part_key & KeyMask;
  assign new_rec = '{key: probe, cls: in_q.part_class, cnt: in_q.on_hand,
                     cost: in_q.cost_cents};
  assign full   = (used_q == CntW'(TABLE_DEPTH));

  always_comb begin
    hit_rec = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      occ[i] = (CntW'(i) < used_q);
      if (eq[i]) hit_rec = recs[i];
    end
  end
  assign hit = |eq;

  always_comb begin
    ctl       = '0;
    ctl.ins   = (state_q == SOne) && (act_q == srts_pkg::ActInsert) && !hit && !full;
    ctl.shift = (state_q == SDump) && (used_q != '0);
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    srts_pkg::rec_t lrec, rrec;
    logic           locc, lgt;
    if (g == 0) begin : g_head
      assign lrec = '0;
      assign locc = 1'b0;
      assign lgt  = 1'b0;
    end else begin : g_body
      assign lrec = recs[g-1];
      assign locc = occ[g-1];
      assign lgt  = gt[g-1];
    end
    // dump rotation: last used cell takes the head record
    assign rrec = (CntW'(g + 1) == used_q) ? recs[0] :
                  ((g + 1 < TABLE_DEPTH) ? recs[(g + 1) % TABLE_DEPTH] : recs[0]);
    srts_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .occ_i       (occ[g]),
      .left_occ_i  (locc),
      .left_gt_i   (lgt),
      .probe_i     (probe),
      .new_i       (new_rec),
      .left_rec_i  (lrec),
      .right_rec_i (rrec),
      .rec_o       (recs[g]),
      .gt_o        (gt[g]),
      .eq_o        (eq[g])
    );
  end

  always_comb begin
    state_d = state_q;
    used_d  = used_q;
    left_d  = left_q;
    case (state_q)
      SIdle: begin
        if (accept) begin
          if (in_i.action inside {srts_pkg::ActInsert, srts_pkg::ActLookup}) begin
            state_d = SOne;
          end else if (in_i.action == srts_pkg::ActDump) begin
            state_d = SDump;
            left_d  = used_q;
          end
        end
      end
      SOne: begin
        state_d = SIdle;
        if (ctl.ins) used_d = used_q + 1'b1;
      end
      SDump: begin
        if (left_q <= CntW'(1)) state_d = SIdle;
        left_d = left_q - 1'b1;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      used_q  <= '0;
      left_q  <= '0;
      p_vld_q <= 1'b0;
      strobe  <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      left_q  <= left_d;
      p_vld_q <= (state_q == SOne) || (state_q == SDump);
      strobe  <= p_vld_q;
    end
  end

  always_comb begin
    p_st_d   = srts_pkg::StOk;
    p_zero_d = 1'b0;
    p_last_d = 1'b1;
    p_rec_d  = hit_rec;
    if (state_q == SOne) begin
      if (act_q == srts_pkg::ActInsert) begin
        if (hit) begin
          p_st_d = srts_pkg::StDuplicate;
        end else if (full) begin
          p_st_d = srts_pkg::StFull;  p_zero_d = 1'b1;
        end else begin
          p_st_d = srts_pkg::StOk;    p_rec_d  = new_rec;
        end
      end else if (hit) begin
        p_st_d = srts_pkg::StOk;
      end else begin
        p_st_d = srts_pkg::StNotFound; p_zero_d = 1'b1;
      end
    end else if (used_q == '0) begin
      p_st_d = srts_pkg::StEmpty; p_zero_d = 1'b1;
    end else begin
      p_st_d   = srts_pkg::StOk;
      p_rec_d  = recs[0];
      p_last_d = (left_q <= CntW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q  <= in_i;
      act_q <= in_i.action;
    end
    p_st_q   <= p_st_d;
    p_zero_q <= p_zero_d;
    p_last_q <= p_last_d;
    p_rec_q  <= p_rec_d;
  end

  always_ff @(posedge clk_i) begin
    out_o.status      <= p_st_q;
    out_o.last_result <= p_last_q;
    if (p_zero_q) begin
      out_o.out_key     <= '0;
      out_o.out_class   <= '0;
      out_o.out_on_hand <= '0;
      out_o.out_cost    <= '0;
      out_o.out_value   <= '0;
    end else begin
      out_o.out_key     <= p_rec_q.key;
      out_o.out_class   <= p_rec_q.cls;
      out_o.out_on_hand <= p_rec_q.cnt;
      out_o.out_cost    <= p_rec_q.cost;
      out_o.out_value   <= 44'(p_rec_q.cnt) * 44'(p_rec_q.cost);
    end
  end

  `SRTS_ASSERT_IMPL(a_used_bound, clk_i, rst_ni, 1'b1, used_q <= CntW'(TABLE_DEPTH))
  `SRTS_ASSERT_IMPL(a_eq_onehot, clk_i, rst_ni, 1'b1, $onehot0(eq))
  `SRTS_ASSERT_NEXT(a_ins_grows, clk_i, rst_ni, ctl.ins, used_q == $past(used_q) + 1'b1)

endmodule
